>>> rtl/lbms_pkg.sv
// lbms_pkg: widths, constants and shared types of the log-bin mean / std-dev unit
// depends on nothing; imported by every rtl module and by the channel interfaces
`default_nettype none

package lbms_pkg;

  localparam int COUNT_BITS = 24;

  localparam int EDGE_W  = 32;
  localparam int VAL_W   = 16;
  localparam int BASE_W  = 16;
  localparam int SUM_W   = 48;
  localparam int SQ_W    = 64;
  localparam int SQR_W   = 2 * VAL_W;
  localparam int PROD_W  = EDGE_W + VAL_W;
  localparam int DIV_W   = 64;
  localparam int ROOT_W  = DIV_W / 2;
  localparam int SUB_W   = ROOT_W + 3;
  localparam int DIV_STEPS  = DIV_W;
  localparam int SQRT_STEPS = DIV_W / 2;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic {
    UNIT_DIV  = 1'b0,
    UNIT_SQRT = 1'b1
  } unit_mode_t;

  typedef struct packed {
    logic       start;
    unit_mode_t mode;
  } unit_ctrl_t;

  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/lbms_if.sv
// lbms_in_if / lbms_out_if: valid-ready channels carrying one input word and one result word
// depends on lbms_pkg for field widths
`default_nettype none

interface lbms_in_if;
  import lbms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [EDGE_W-1:0]       level;
  logic signed [VAL_W-1:0] sample_value;
  logic                    end_of_data;

  modport source (output valid, output level, output sample_value, output end_of_data,
                  input ready);
  modport sink (input valid, input level, input sample_value, input end_of_data,
                output ready);
endinterface

interface lbms_out_if;
  import lbms_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [EDGE_W-1:0]       bin_upper_edge;
  logic signed [VAL_W-1:0] bin_mean;
  logic [VAL_W-1:0]        bin_std_dev;
  logic [VAL_W-1:0]        bin_std_err;
  logic                    final_result;

  modport source (output valid, output bin_upper_edge, output bin_mean, output bin_std_dev,
                  output bin_std_err, output final_result, input ready);
  modport sink (input valid, input bin_upper_edge, input bin_mean, input bin_std_dev,
                input bin_std_err, input final_result, output ready);
endinterface

`default_nettype wire

>>> rtl/lbms_iter_unit.sv
// lbms_iter_unit: shared bit-serial divider and integer square root, one subtractor
// depends on lbms_pkg
`default_nettype none

module lbms_iter_unit import lbms_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire unit_ctrl_t       ctrl,
  input  wire logic [DIV_W-1:0] operand,
  input  wire count_t           divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      result
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  unit_mode_t        mode_r;
  logic [DIV_W-1:0]  acc_r;
  logic [SUB_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;

  logic [SUB_W-1:0]  sub_a;
  logic [SUB_W-1:0]  sub_b;
  logic [SUB_W:0]    diff;
  logic              fits;

  always_comb begin
    if (mode_r == UNIT_SQRT) begin
      sub_a = {rem_r[SUB_W-3:0], acc_r[DIV_W-1 -: 2]};
      sub_b = {{(SUB_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    end else begin
      sub_a = {rem_r[SUB_W-2:0], acc_r[DIV_W-1]};
      sub_b = {{(SUB_W-COUNT_BITS){1'b0}}, divisor};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    fits = ~diff[SUB_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        step_r <= (ctrl.mode == UNIT_SQRT) ? STEP_W'(SQRT_STEPS - 1) : STEP_W'(DIV_STEPS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      mode_r <= ctrl.mode;
      acc_r  <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[SUB_W-1:0] : sub_a;
      if (mode_r == UNIT_SQRT) begin
        acc_r  <= {acc_r[DIV_W-3:0], 2'b00};
        root_r <= {root_r[ROOT_W-2:0], fits};
      end else begin
        acc_r <= {acc_r[DIV_W-2:0], fits};
      end
    end
  end

  assign done   = done_r;
  assign result = (mode_r == UNIT_SQRT) ? {{(DIV_W-ROOT_W){1'b0}}, root_r} : acc_r;

endmodule

`default_nettype wire

>>> rtl/lbms_bin_acc.sv
// lbms_bin_acc: saturating value sum, square sum and sample count of the open bin
// depends on lbms_pkg
`default_nettype none

module lbms_bin_acc import lbms_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acc_ctrl_t        ctrl,
  input  wire logic [VAL_W-1:0] value,
  input  wire logic [SQR_W-1:0] square,
  output logic [SUM_W-1:0]      value_sum,
  output logic [SQ_W-1:0]       square_sum,
  output count_t                sample_count
);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  logic [SUM_W-1:0] sum_r;
  logic [SQ_W-1:0]  sq_r;
  count_t           count_r;

  logic [SUM_W:0]   sum_ext;
  logic [SQ_W:0]    sq_ext;
  logic [SUM_W-1:0] sum_nxt;
  logic [SQ_W-1:0]  sq_nxt;

  always_comb begin
    sum_ext = {sum_r[SUM_W-1], sum_r} + {{(SUM_W+1-VAL_W){value[VAL_W-1]}}, value};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_nxt = sum_ext[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
    sq_ext = {1'b0, sq_r} + {{(SQ_W+1-SQR_W){1'b0}}, square};
    sq_nxt = sq_ext[SQ_W] ? '1 : sq_ext[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      sum_r   <= '0;
      sq_r    <= '0;
      count_r <= '0;
    end else if (ctrl.add && (count_r != '1)) begin
      sum_r   <= sum_nxt;
      sq_r    <= sq_nxt;
      count_r <= count_r + COUNT_BITS'(1);
    end
  end

  assign value_sum    = sum_r;
  assign square_sum   = sq_r;
  assign sample_count = count_r;

endmodule

`default_nettype wire

>>> rtl/log_bin_mean_stddev_unit.sv
// log_bin_mean_stddev_unit: top level, sequencer, shared multiplier and result register
// depends on lbms_pkg, lbms_if, lbms_iter_unit and lbms_bin_acc
//
// Takes (level, sample_value, end_of_data) words sorted by level and sums each sample into
// the bin whose upper edge is the first power of bin_base at or above its level. A word that
// stays in the open bin is accepted and squared in the idle state, then compared with the edge
// and accumulated in the check state. Closing a bin computes mean, standard deviation and
// standard error on one shared unit that divides or takes a square root one result bit per
// cycle: three 64-step divisions and two 32-step roots. Each step of edge growth runs the
// check, multiply and update states on the multiplier. With end_of_data set the final bin is
// always reported, marked by final_result, after any bin that the same word closed. Results
// sit in an output register, so input is taken again while the last result waits. A write on
// cfg_we loads bin_base (values below 2 act as 2), resets the edge and starts a new data set;
// write it only while the block is idle.
`default_nettype none

module log_bin_mean_stddev_unit import lbms_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [BASE_W-1:0] cfg_wdata,
  lbms_in_if.sink                in_word,
  lbms_out_if.source             out_word
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_CHECK    = 14'b00000000000010,
    S_DIV_MEAN = 14'b00000000000100,
    S_SQR_MEAN = 14'b00000000001000,
    S_DIV_MS   = 14'b00000000010000,
    S_SQRT_SD  = 14'b00000000100000,
    S_DIV_VN   = 14'b00000001000000,
    S_SQRT_SE  = 14'b00000010000000,
    S_OUT      = 14'b00000100000000,
    S_GROW_CHK = 14'b00001000000000,
    S_GROW_MUL = 14'b00010000000000,
    S_GROW_UPD = 14'b00100000000000,
    S_ACC      = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_t;

  function automatic logic [BASE_W-1:0] eff_base_of(input logic [BASE_W-1:0] b);
    return (b < BASE_MIN) ? BASE_MIN : b;
  endfunction

  function automatic logic [VAL_W-1:0] clamp16(input logic [DIV_W-1:0] x);
    return (x[DIV_W-1:VAL_W] != '0) ? '1 : x[VAL_W-1:0];
  endfunction

  state_t            state_r, state_nxt;
  logic              first_r;
  logic [BASE_W-1:0] bin_base_r;
  logic [EDGE_W-1:0] edge_r;
  logic [EDGE_W-1:0] level_r;
  logic [VAL_W-1:0]  value_r;
  logic              eod_r;
  logic [SQR_W-1:0]  sq_r;
  logic [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]  mean_q_r;
  logic [DIV_W-1:0]  var_r;
  logic [VAL_W-1:0]  sd_r;
  logic              final_r;

  logic              out_valid_r;
  logic [EDGE_W-1:0] out_edge_r;
  logic [VAL_W-1:0]  out_mean_r;
  logic [VAL_W-1:0]  out_sd_r;
  logic [VAL_W-1:0]  out_se_r;
  logic              out_final_r;

  logic [BASE_W-1:0] eff_base;
  logic              level_gt;
  logic              in_take;
  logic              out_load;
  logic [VAL_W-1:0]  abs_in;
  logic [EDGE_W-1:0] mul_a;
  logic [VAL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [SUM_W-1:0]  mag;
  logic              sum_neg;
  logic [DIV_W-1:0]  m2_ext;

  acc_ctrl_t         acc_ctrl;
  unit_ctrl_t        unit_ctrl;
  logic [DIV_W-1:0]  unit_operand;
  logic              unit_done;
  logic [DIV_W-1:0]  unit_result;
  logic [SUM_W-1:0]  value_sum;
  logic [SQ_W-1:0]   square_sum;
  count_t            sample_count;

  lbms_bin_acc u_acc (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (acc_ctrl),
    .value        (value_r),
    .square       (sq_r),
    .value_sum    (value_sum),
    .square_sum   (square_sum),
    .sample_count (sample_count)
  );

  lbms_iter_unit u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (unit_ctrl),
    .operand (unit_operand),
    .divisor (sample_count),
    .done    (unit_done),
    .result  (unit_result)
  );

  assign eff_base = eff_base_of(bin_base_r);
  assign level_gt = level_r > edge_r;
  assign in_take  = in_word.valid && (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_word.ready);
  assign abs_in   = in_word.sample_value[VAL_W-1] ?
                    (~in_word.sample_value + VAL_W'(1)) : in_word.sample_value;
  assign sum_neg  = value_sum[SUM_W-1];
  assign mag      = sum_neg ? (~value_sum + SUM_W'(1)) : value_sum;
  assign m2_ext   = DIV_W'(prod_r[SQR_W-1:0]);

  // shared multiplier
  always_comb begin
    mul_a = edge_r;
    mul_b = eff_base;
    case (state_r)
      S_IDLE: begin
        mul_a = EDGE_W'(abs_in);
        mul_b = abs_in;
      end
      S_SQR_MEAN: begin
        mul_a = EDGE_W'(mean_q_r);
        mul_b = mean_q_r;
      end
      default: begin
        mul_a = edge_r;
        mul_b = eff_base;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    state_nxt      = state_r;
    acc_ctrl.add   = 1'b0;
    acc_ctrl.clear = cfg_we;
    unit_ctrl.start = 1'b0;
    unit_ctrl.mode  = UNIT_DIV;
    unit_operand    = var_r;
    case (state_r)
      S_IDLE: begin
        if (in_take) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (level_gt) begin
          state_nxt = (sample_count != '0) ? S_DIV_MEAN : S_GROW_CHK;
        end else begin
          acc_ctrl.add = 1'b1;
          state_nxt = eod_r ? S_DIV_MEAN : S_IDLE;
        end
      end
      S_DIV_MEAN: begin
        unit_ctrl.start = first_r;
        unit_operand    = DIV_W'(mag) + DIV_W'(sample_count >> 1);
        if (unit_done) state_nxt = S_SQR_MEAN;
      end
      S_SQR_MEAN: begin
        state_nxt = S_DIV_MS;
      end
      S_DIV_MS: begin
        unit_ctrl.start = first_r;
        unit_operand    = square_sum;
        if (unit_done) state_nxt = S_SQRT_SD;
      end
      S_SQRT_SD: begin
        unit_ctrl.start = first_r;
        unit_ctrl.mode  = UNIT_SQRT;
        if (unit_done) state_nxt = S_DIV_VN;
      end
      S_DIV_VN: begin
        unit_ctrl.start = first_r;
        if (unit_done) state_nxt = S_SQRT_SE;
      end
      S_SQRT_SE: begin
        unit_ctrl.start = first_r;
        unit_ctrl.mode  = UNIT_SQRT;
        unit_operand    = unit_result;
        if (unit_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        unit_ctrl.mode = UNIT_SQRT;
        if (out_load) begin
          acc_ctrl.clear = 1'b1;
          state_nxt = final_r ? S_IDLE : S_GROW_CHK;
        end
      end
      S_GROW_CHK: begin
        state_nxt = level_gt ? S_GROW_MUL : S_ACC;
      end
      S_GROW_MUL: begin
        state_nxt = S_GROW_UPD;
      end
      S_GROW_UPD: begin
        state_nxt = S_GROW_CHK;
      end
      S_ACC: begin
        acc_ctrl.add = 1'b1;
        state_nxt = eod_r ? S_DIV_MEAN : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      bin_base_r  <= BASE_RESET;
      edge_r      <= EDGE_W'(eff_base_of(BASE_RESET));
      final_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= (state_nxt != state_r);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CHECK: begin
          final_r <= !level_gt;
        end
        S_ACC: begin
          final_r <= 1'b1;
        end
        S_GROW_UPD: begin
          edge_r <= (prod_r[PROD_W-1:EDGE_W] != '0) ? '1 : prod_r[EDGE_W-1:0];
        end
        S_OUT: begin
          if (out_load && final_r) edge_r <= EDGE_W'(eff_base);
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        bin_base_r <= cfg_wdata;
        edge_r     <= EDGE_W'(eff_base_of(cfg_wdata));
      end
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (in_take) begin
      level_r <= in_word.level;
      value_r <= in_word.sample_value;
      eod_r   <= in_word.end_of_data;
      sq_r    <= mul_p[SQR_W-1:0];
    end
    if ((state_r == S_SQR_MEAN) || (state_r == S_GROW_MUL)) begin
      prod_r <= mul_p;
    end
    if (unit_done) begin
      case (state_r)
        S_DIV_MEAN: mean_q_r <= unit_result[VAL_W-1:0];
        S_DIV_MS:   var_r <= (unit_result > m2_ext) ? (unit_result - m2_ext) : '0;
        S_SQRT_SD:  sd_r <= clamp16(unit_result);
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_edge_r  <= edge_r;
      out_mean_r  <= sum_neg ? (~mean_q_r + VAL_W'(1)) : mean_q_r;
      out_sd_r    <= sd_r;
      out_se_r    <= clamp16(unit_result);
      out_final_r <= final_r;
    end
  end

  assign in_word.ready           = (state_r == S_IDLE);
  assign out_word.valid          = out_valid_r;
  assign out_word.bin_upper_edge = out_edge_r;
  assign out_word.bin_mean       = out_mean_r;
  assign out_word.bin_std_dev    = out_sd_r;
  assign out_word.bin_std_err    = out_se_r;
  assign out_word.final_result   = out_final_r;

endmodule

`default_nettype wire

>>> bench/log_bin_mean_stddev_unit_tb.sv
// log_bin_mean_stddev_unit_tb: self-checking bench for the log-bin mean / std-dev unit
// drives sorted level/value words through the valid-ready channels and checks every bin result
// depends on lbms_pkg, lbms_if and log_bin_mean_stddev_unit
module log_bin_mean_stddev_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbms_pkg::*;

  typedef struct packed {
    logic [EDGE_W-1:0] upper_edge;
    logic [VAL_W-1:0]  mean;
    logic [VAL_W-1:0]  std_dev;
    logic [VAL_W-1:0]  std_err;
    logic              final_flag;
  } bin_stats_t;

  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint unsigned COUNT_FULL = (64'd1 << COUNT_BITS) - 1;
  localparam int SETTLE_CYCLES = 400;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;

  lbms_in_if  in_ch ();
  lbms_out_if out_ch ();

  log_bin_mean_stddev_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_word  (in_ch),
    .out_word (out_ch)
  );

  bin_stats_t expected_bins[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  logic [BASE_W-1:0] model_base;
  logic [EDGE_W-1:0] model_edge;
  longint            model_sum;
  logic [63:0]       model_sq;
  longint unsigned   model_count;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 64'd0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [EDGE_W-1:0] eff_base();
    return (model_base < BASE_MIN) ? EDGE_W'(BASE_MIN) : EDGE_W'(model_base);
  endfunction

  function automatic void clear_bin();
    model_sum = 0;
    model_sq = 64'd0;
    model_count = 0;
  endfunction

  function automatic void add_sample(input logic signed [VAL_W-1:0] v);
    logic [63:0] sq;
    if (model_count >= COUNT_FULL) return;
    model_count++;
    model_sum = model_sum + longint'(v);
    if (model_sum > SUM_HI) model_sum = SUM_HI;
    if (model_sum < SUM_LO) model_sum = SUM_LO;
    sq = 64'(longint'(v) * longint'(v));
    if (model_sq > ~64'd0 - sq) model_sq = ~64'd0;
    else model_sq = model_sq + sq;
  endfunction

  function automatic bin_stats_t bin_stats(input logic fin);
    logic [63:0] n, mag, q, ms, m2, spread, sd, se;
    longint m;
    bin_stats_t r;
    n = model_count;
    mag = (model_sum < 0) ? 64'(-model_sum) : 64'(model_sum);
    q = (mag + n / 2) / n;
    m = (model_sum < 0) ? -longint'(q) : longint'(q);
    ms = model_sq / n;
    m2 = 64'(m * m);
    spread = (ms > m2) ? ms - m2 : 64'd0;
    sd = int_sqrt(spread);
    se = int_sqrt(spread / n);
    r.upper_edge = model_edge;
    r.mean = m[VAL_W-1:0];
    r.std_dev = (sd > 64'hFFFF) ? 16'hFFFF : sd[VAL_W-1:0];
    r.std_err = (se > 64'hFFFF) ? 16'hFFFF : se[VAL_W-1:0];
    r.final_flag = fin;
    return r;
  endfunction

  function automatic void predict_bins(input logic [EDGE_W-1:0] level,
                                       input logic signed [VAL_W-1:0] v, input logic eod);
    logic [63:0] grown;
    logic [EDGE_W-1:0] b;
    if (level > model_edge) begin
      b = eff_base();
      if (model_count != 0) expected_bins = {expected_bins, bin_stats(1'b0)};
      clear_bin();
      while (level > model_edge) begin
        grown = 64'(model_edge) * 64'(b);
        model_edge = (grown > 64'hFFFF_FFFF) ? '1 : grown[EDGE_W-1:0];
      end
    end
    add_sample(v);
    if (eod) begin
      if (model_count != 0) expected_bins = {expected_bins, bin_stats(1'b1)};
      clear_bin();
      model_edge = eff_base();
    end
  endfunction

  function automatic logic [EDGE_W-1:0] level_mask();
    int k;
    k = ($urandom_range(9) < 7) ? $urandom_range(2) : $urandom_range(32);
    return (k == 32) ? '1 : (EDGE_W'(1) << k) - 1;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return VAL_W'(r[9:0]) - 16'd512;
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  task automatic send_word(input logic [EDGE_W-1:0] level, input logic [VAL_W-1:0] value,
                           input logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.level        <= level;
    in_ch.sample_value <= value;
    in_ch.end_of_data  <= eod;
    do @(posedge clk); while (!in_ch.ready);
    predict_bins(level, value, eod);
  endtask

  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_bins.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_base = v;
    model_edge = eff_base();
    clear_bin();
  endtask

  task automatic test_default_base();
    send_word(32'd0, 16'h7FFF, 1'b0);
    send_word(32'd5, 16'h8000, 1'b0);
    send_word(32'd10, 16'h0001, 1'b0);
    send_word(32'd11, 16'hFFFF, 1'b0);
    send_word(32'd100, 16'h0100, 1'b0);
    send_word(32'd5000, 16'h8000, 1'b0);
    send_word(32'd20000, 16'h7FFF, 1'b1);
    // empty bin crossed, then a level below the edge
    send_word(32'd1000, 16'h1234, 1'b0);
    send_word(32'd3, 16'h00FF, 1'b0);
    // edge growth saturates
    send_word(32'hFFFF_FFFF, 16'h5555, 1'b0);
    send_word(32'hFFFF_FFFF, 16'hAAAA, 1'b1);
    settle();
  endtask

  task automatic test_base_extremes();
    write_base(16'd2);
    send_word(32'd0, 16'h0000, 1'b0);
    send_word(32'd1, 16'h0080, 1'b0);
    send_word(32'd2, 16'hFF80, 1'b0);
    send_word(32'd3, 16'h0001, 1'b0);
    send_word(32'h8000_0001, 16'h7FFF, 1'b1);
    settle();
    write_base(16'hFFFF);
    send_word(32'd65535, 16'h7FFF, 1'b0);
    send_word(32'd65536, 16'h8000, 1'b0);
    send_word(32'hFFFF_FFFF, 16'h0000, 1'b1);
    settle();
    // bases below two act as two
    write_base(16'd0);
    send_word(32'd3, 16'h0100, 1'b0);
    send_word(32'd5, 16'h0200, 1'b1);
    settle();
    write_base(16'd1);
    send_word(32'd2, 16'h0300, 1'b0);
    // rewrite with a bin still open
    settle();
    write_base(16'd7);
    send_word(32'd7, 16'hFD00, 1'b1);
    settle();
  endtask

  task automatic test_random_sets(input int idle_pct, input int stall,
                                  input logic [BASE_W-1:0] base, input int items);
    int sent;
    int set_left;
    bit paused;
    logic [EDGE_W-1:0] lvl;
    logic [EDGE_W:0] nxt;
    sent = 0;
    paused = 1'b0;
    settle();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    write_base(base);
    while (sent < items) begin
      if (!paused && sent >= items / 2) begin
        wait_results();
        paused = 1'b1;
      end else if ($urandom_range(299) == 0) begin
        wait_results();
      end
      if ($urandom_range(9) == 0) begin
        send_word($urandom, random_value(), ($urandom_range(7) == 0));
        sent++;
      end else begin
        set_left = $urandom_range(1, 24);
        lvl = $urandom & level_mask();
        // some sets are cut short without an end marker
        if ($urandom_range(7) == 0) set_left = -set_left;
        while (set_left != 0) begin
          nxt = {1'b0, lvl} + {1'b0, $urandom & level_mask()};
          lvl = nxt[EDGE_W] ? '1 : nxt[EDGE_W-1:0];
          send_word(lvl, random_value(), (set_left == 1));
          sent++;
          set_left = (set_left > 0) ? set_left - 1 : set_left + 1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    bin_stats_t got;
    bin_stats_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.bin_upper_edge, out_ch.bin_mean, out_ch.bin_std_dev, out_ch.bin_std_err,
             out_ch.final_result};
      if (expected_bins.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected word: edge %0d mean %0d sd %0d se %0d final %0b",
                   got.upper_edge, $signed(got.mean), got.std_dev, got.std_err, got.final_flag);
      end else begin
        want = expected_bins.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected edge %0d mean %0d sd %0d se %0d final %0b, ",
                     want.upper_edge, $signed(want.mean), want.std_dev, want.std_err,
                     want.final_flag,
                     "got edge %0d mean %0d sd %0d se %0d final %0b",
                     got.upper_edge, $signed(got.mean), got.std_dev,
                     got.std_err, got.final_flag);
        end
      end
    end
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.level        <= '0;
    in_ch.sample_value <= '0;
    in_ch.end_of_data  <= 1'b0;
    model_base = BASE_RESET;
    model_edge = eff_base();
    clear_bin();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_base();
    test_base_extremes();
    test_random_sets(0, 0, 16'd2, 412);
    test_random_sets(63, 0, 16'($urandom_range(3, 20)), 412);
    test_random_sets(0, 63, 16'hFFFF, 412);
    test_random_sets(32, 32, 16'($urandom_range(2, 300)), 412);
    settle();

    if (fail_count == 0 && expected_bins.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
